>>> rtl/srpe_pkg.sv
package srpe_pkg;

  localparam int STAR_COUNT = 512;
  localparam int IDX_W = 9;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic signed [15:0] Z_BIAS = 16'sd9000;
  localparam logic signed [15:0] Z_NEAR = 16'sd100;
  localparam logic signed [15:0] ROW_OFS = 16'sd84;
  localparam logic signed [15:0] COL_OFS = 16'sd312;
  localparam logic [15:0] ROW_LIM = 16'd167;
  localparam logic [15:0] COL_LIM = 16'd624;
  localparam logic [7:0] SHADE_BASE = 8'd14;
  localparam logic [15:0] ANG_X_INC = 16'd192;
  localparam logic [15:0] ANG_Y_INC = 16'd128;
  localparam logic [15:0] ANG_Z_INC = 16'hFFC0;

  typedef logic [18:0] pix_t;

  function automatic logic [14:0] quarter_sine(input logic [8:0] j);
    logic [14:0] r;
    case (j)
      9'd0: r=15'h0000; 9'd1: r=15'h00C9; 9'd2: r=15'h0192; 9'd3: r=15'h025B;
      9'd4: r=15'h0324; 9'd5: r=15'h03ED; 9'd6: r=15'h04B6; 9'd7: r=15'h057F;
      9'd8: r=15'h0648; 9'd9: r=15'h0711; 9'd10: r=15'h07D9; 9'd11: r=15'h08A2;
      9'd12: r=15'h096A; 9'd13: r=15'h0A33; 9'd14: r=15'h0AFB; 9'd15: r=15'h0BC3;
      9'd16: r=15'h0C8C; 9'd17: r=15'h0D54; 9'd18: r=15'h0E1C; 9'd19: r=15'h0EE3;
      9'd20: r=15'h0FAB; 9'd21: r=15'h1072; 9'd22: r=15'h113A; 9'd23: r=15'h1201;
      9'd24: r=15'h12C8; 9'd25: r=15'h138F; 9'd26: r=15'h1455; 9'd27: r=15'h151C;
      9'd28: r=15'h15E2; 9'd29: r=15'h16A8; 9'd30: r=15'h176D; 9'd31: r=15'h1833;
      9'd32: r=15'h18F8; 9'd33: r=15'h19BD; 9'd34: r=15'h1A82; 9'd35: r=15'h1B47;
      9'd36: r=15'h1C0B; 9'd37: r=15'h1CCF; 9'd38: r=15'h1D93; 9'd39: r=15'h1E56;
      9'd40: r=15'h1F19; 9'd41: r=15'h1FDC; 9'd42: r=15'h209F; 9'd43: r=15'h2161;
      9'd44: r=15'h2223; 9'd45: r=15'h22E5; 9'd46: r=15'h23A6; 9'd47: r=15'h2467;
      9'd48: r=15'h2527; 9'd49: r=15'h25E8; 9'd50: r=15'h26A8; 9'd51: r=15'h2767;
      9'd52: r=15'h2826; 9'd53: r=15'h28E5; 9'd54: r=15'h29A3; 9'd55: r=15'h2A61;
      9'd56: r=15'h2B1F; 9'd57: r=15'h2BDC; 9'd58: r=15'h2C98; 9'd59: r=15'h2D55;
      9'd60: r=15'h2E10; 9'd61: r=15'h2ECC; 9'd62: r=15'h2F87; 9'd63: r=15'h3041;
      9'd64: r=15'h30FB; 9'd65: r=15'h31B5; 9'd66: r=15'h326E; 9'd67: r=15'h3326;
      9'd68: r=15'h33DE; 9'd69: r=15'h3496; 9'd70: r=15'h354D; 9'd71: r=15'h3603;
      9'd72: r=15'h36B9; 9'd73: r=15'h376F; 9'd74: r=15'h3824; 9'd75: r=15'h38D8;
      9'd76: r=15'h398C; 9'd77: r=15'h3A3F; 9'd78: r=15'h3AF2; 9'd79: r=15'h3BA4;
      9'd80: r=15'h3C56; 9'd81: r=15'h3D07; 9'd82: r=15'h3DB7; 9'd83: r=15'h3E67;
      9'd84: r=15'h3F16; 9'd85: r=15'h3FC5; 9'd86: r=15'h4073; 9'd87: r=15'h4120;
      9'd88: r=15'h41CD; 9'd89: r=15'h4279; 9'd90: r=15'h4325; 9'd91: r=15'h43D0;
      9'd92: r=15'h447A; 9'd93: r=15'h4523; 9'd94: r=15'h45CC; 9'd95: r=15'h4674;
      9'd96: r=15'h471C; 9'd97: r=15'h47C3; 9'd98: r=15'h4869; 9'd99: r=15'h490E;
      9'd100: r=15'h49B3; 9'd101: r=15'h4A57; 9'd102: r=15'h4AFA; 9'd103: r=15'h4B9D;
      9'd104: r=15'h4C3F; 9'd105: r=15'h4CE0; 9'd106: r=15'h4D80; 9'd107: r=15'h4E20;
      9'd108: r=15'h4EBF; 9'd109: r=15'h4F5D; 9'd110: r=15'h4FFA; 9'd111: r=15'h5097;
      9'd112: r=15'h5133; 9'd113: r=15'h51CE; 9'd114: r=15'h5268; 9'd115: r=15'h5301;
      9'd116: r=15'h539A; 9'd117: r=15'h5432; 9'd118: r=15'h54C9; 9'd119: r=15'h555F;
      9'd120: r=15'h55F4; 9'd121: r=15'h5689; 9'd122: r=15'h571D; 9'd123: r=15'h57AF;
      9'd124: r=15'h5841; 9'd125: r=15'h58D3; 9'd126: r=15'h5963; 9'd127: r=15'h59F2;
      9'd128: r=15'h5A81; 9'd129: r=15'h5B0F; 9'd130: r=15'h5B9C; 9'd131: r=15'h5C28;
      9'd132: r=15'h5CB3; 9'd133: r=15'h5D3D; 9'd134: r=15'h5DC6; 9'd135: r=15'h5E4F;
      9'd136: r=15'h5ED6; 9'd137: r=15'h5F5D; 9'd138: r=15'h5FE2; 9'd139: r=15'h6067;
      9'd140: r=15'h60EB; 9'd141: r=15'h616E; 9'd142: r=15'h61EF; 9'd143: r=15'h6270;
      9'd144: r=15'h62F0; 9'd145: r=15'h6370; 9'd146: r=15'h63EE; 9'd147: r=15'h646B;
      9'd148: r=15'h64E7; 9'd149: r=15'h6562; 9'd150: r=15'h65DC; 9'd151: r=15'h6656;
      9'd152: r=15'h66CE; 9'd153: r=15'h6745; 9'd154: r=15'h67BB; 9'd155: r=15'h6831;
      9'd156: r=15'h68A5; 9'd157: r=15'h6918; 9'd158: r=15'h698A; 9'd159: r=15'h69FC;
      9'd160: r=15'h6A6C; 9'd161: r=15'h6ADB; 9'd162: r=15'h6B49; 9'd163: r=15'h6BB6;
      9'd164: r=15'h6C22; 9'd165: r=15'h6C8E; 9'd166: r=15'h6CF8; 9'd167: r=15'h6D60;
      9'd168: r=15'h6DC8; 9'd169: r=15'h6E2F; 9'd170: r=15'h6E95; 9'd171: r=15'h6EFA;
      9'd172: r=15'h6F5D; 9'd173: r=15'h6FC0; 9'd174: r=15'h7021; 9'd175: r=15'h7082;
      9'd176: r=15'h70E1; 9'd177: r=15'h713F; 9'd178: r=15'h719C; 9'd179: r=15'h71F8;
      9'd180: r=15'h7253; 9'd181: r=15'h72AD; 9'd182: r=15'h7306; 9'd183: r=15'h735E;
      9'd184: r=15'h73B4; 9'd185: r=15'h740A; 9'd186: r=15'h745E; 9'd187: r=15'h74B1;
      9'd188: r=15'h7503; 9'd189: r=15'h7554; 9'd190: r=15'h75A4; 9'd191: r=15'h75F2;
      9'd192: r=15'h7640; 9'd193: r=15'h768C; 9'd194: r=15'h76D7; 9'd195: r=15'h7722;
      9'd196: r=15'h776A; 9'd197: r=15'h77B2; 9'd198: r=15'h77F9; 9'd199: r=15'h783E;
      9'd200: r=15'h7883; 9'd201: r=15'h78C6; 9'd202: r=15'h7908; 9'd203: r=15'h7949;
      9'd204: r=15'h7988; 9'd205: r=15'h79C7; 9'd206: r=15'h7A04; 9'd207: r=15'h7A40;
      9'd208: r=15'h7A7B; 9'd209: r=15'h7AB5; 9'd210: r=15'h7AED; 9'd211: r=15'h7B25;
      9'd212: r=15'h7B5B; 9'd213: r=15'h7B90; 9'd214: r=15'h7BC4; 9'd215: r=15'h7BF7;
      9'd216: r=15'h7C28; 9'd217: r=15'h7C58; 9'd218: r=15'h7C87; 9'd219: r=15'h7CB5;
      9'd220: r=15'h7CE2; 9'd221: r=15'h7D0D; 9'd222: r=15'h7D38; 9'd223: r=15'h7D61;
      9'd224: r=15'h7D88; 9'd225: r=15'h7DAF; 9'd226: r=15'h7DD4; 9'd227: r=15'h7DF9;
      9'd228: r=15'h7E1C; 9'd229: r=15'h7E3D; 9'd230: r=15'h7E5E; 9'd231: r=15'h7E7D;
      9'd232: r=15'h7E9B; 9'd233: r=15'h7EB8; 9'd234: r=15'h7ED4; 9'd235: r=15'h7EEE;
      9'd236: r=15'h7F08; 9'd237: r=15'h7F20; 9'd238: r=15'h7F36; 9'd239: r=15'h7F4C;
      9'd240: r=15'h7F60; 9'd241: r=15'h7F73; 9'd242: r=15'h7F85; 9'd243: r=15'h7F96;
      9'd244: r=15'h7FA5; 9'd245: r=15'h7FB3; 9'd246: r=15'h7FC0; 9'd247: r=15'h7FCC;
      9'd248: r=15'h7FD7; 9'd249: r=15'h7FE0; 9'd250: r=15'h7FE8; 9'd251: r=15'h7FEF;
      9'd252: r=15'h7FF4; 9'd253: r=15'h7FF8; 9'd254: r=15'h7FFC; 9'd255: r=15'h7FFD;
      9'd256: r=15'h7FFE;
      default: r = 15'h0000;
    endcase
    return r;
  endfunction

  // 1024 steps per turn, mirrored quarter wave
  function automatic logic signed [15:0] rom_sine(input logic [9:0] i);
    logic [8:0] j;
    logic signed [15:0] v;
    j = {1'b0, i[7:0]};
    if (i[8]) j = 9'd256 - {1'b0, i[7:0]};
    v = $signed({1'b0, quarter_sine(j)});
    return i[9] ? -v : v;
  endfunction

  function automatic logic [1:0] depth_shade(input logic [4:0] c);
    logic [1:0] r;
    case (c)
      5'd11, 5'd12, 5'd13: r = 2'd1;
      default: r = (c >= 5'd14) ? 2'd3 : 2'd2;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/star_rotate_project_engine_core.sv
// channel   dir  signals
// request   in   in_valid/in_ready, opcode star_index load_x load_y load_z
// result    out  out_valid/out_ready, erase_* draw_* shade
// config    in   cfg_we/cfg_data (star_speed)
//
// a load or unused opcode goes straight to the result, a frame builds the
// matrix first; a star is culled on depth, clipped on the row, or takes both
// divisions in turn through the shared serial divider
// one request at a time; the next is taken the cycle after the result leaves
// rst clears the angles, matrix and speed, then a pass over all 512 entries
// clears the last-pixel table while in_ready stays low
// a stalled result simply holds; no new request enters meanwhile
module star_rotate_project_engine_core import srpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [8:0]  star_index,
  input  logic signed [15:0] load_x,
  input  logic signed [15:0] load_y,
  input  logic signed [15:0] load_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        erase_valid,
  output logic [9:0]  erase_col,
  output logic [7:0]  erase_row,
  output logic        draw_valid,
  output logic [9:0]  draw_col,
  output logic [7:0]  draw_row,
  output logic [1:0]  shade
);

  localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_FRAME = 4'd2,
    S_MAC = 4'd3, S_ACC = 4'd4, S_DIVY = 4'd5, S_WAITY = 4'd6,
    S_DIVX = 4'd7, S_WAITX = 4'd8, S_DONE = 4'd9, S_OUT = 4'd10,
    S_CLR = 4'd11;

  logic [3:0] state;

  // star memories, registered read
  logic signed [15:0] mem_x [STAR_COUNT];
  logic signed [15:0] mem_y [STAR_COUNT];
  logic signed [15:0] mem_z [STAR_COUNT];
  // last pixel: bit 18 valid, then column and row
  pix_t               mem_p [STAR_COUNT];
  logic signed [15:0] rd_x, rd_y, rd_z;
  pix_t               rd_p;

  logic [9:0]  speed;
  logic [15:0] ang [3];
  logic signed [15:0] mat [9];

  logic [8:0]  idx_r;
  logic signed [15:0] lx, ly, lz;

  logic signed [15:0] zs;
  logic [1:0]  mac_cnt;
  logic signed [31:0] pr0, pr1, pr2;
  logic signed [15:0] vx, vy, vz, py_r, px_r;

  logic        div_start, div_done;
  logic signed [31:0] div_num, div_q;

  logic        in_range;
  assign in_range = 1'b1;
  assign in_ready = (state == S_IDLE) && !out_valid;

  srpe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(vz),
    .done(div_done), .quotient(div_q)
  );

  // frame matrix build, computed combinationally from next angles (narrow products)
  logic [15:0] na0, na1, na2;
  logic signed [15:0] sa, sb, sc, ca, cb, cc, sab, cab;
  function automatic logic signed [15:0] m16(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    return p[31:16];
  endfunction
  assign na0 = ang[0] + ANG_X_INC;
  assign na1 = ang[1] + ANG_Y_INC;
  assign na2 = ang[2] + ANG_Z_INC;
  assign sa = rom_sine(na0[15:6]);
  assign sb = rom_sine(na1[15:6]);
  assign sc = rom_sine(na2[15:6]);
  assign ca = rom_sine(na0[15:6] + 10'd256);
  assign cb = rom_sine(na1[15:6] + 10'd256);
  assign cc = rom_sine(na2[15:6] + 10'd256);
  logic signed [15:0] sab_r, cab_r;
  assign sab = m16(sa, sb);
  assign cab = m16(ca, sb);

  // row selection for the rotation: mac_cnt 0 = z row, 1 = y row, 2 = x row
  logic signed [15:0] m0, m1, m2;
  always_comb begin
    case (mac_cnt)
      2'd0: begin m0 = mat[2]; m1 = mat[5]; m2 = mat[8]; end
      2'd1: begin m0 = mat[1]; m1 = mat[4]; m2 = mat[7]; end
      default: begin m0 = mat[0]; m1 = mat[3]; m2 = mat[6]; end
    endcase
  end

  logic signed [15:0] acc;
  assign acc = 16'(pr0 >>> 16) + 16'(pr1 >>> 16) + 16'(pr2 >>> 16);

  logic signed [31:0] tx;
  assign tx = 32'(vx >>> 2) + 32'(vx);

  logic signed [15:0] py_w, px_w;
  assign py_w = 16'(div_q) + ROW_OFS;
  assign px_w = 16'(div_q) + COL_OFS;

  logic [7:0] col8;
  assign col8 = ((~vz[15:8]) >> 3) - SHADE_BASE;

  pix_t mem_wp;
  logic pwe;
  logic zwe;

  // one write port on the last-pixel table: clearing pass, load, step
  logic [8:0] clr_addr;
  logic       p_we;
  logic [8:0] p_addr;
  pix_t       p_wdata;

  always_comb begin
    p_we = 1'b0;
    p_addr = idx_r;
    p_wdata = mem_wp;
    if (state == S_CLR) begin
      p_we = 1'b1;
      p_addr = clr_addr;
      p_wdata = '0;
    end else if (in_valid && in_ready && opcode == OP_LOAD) begin
      p_we = 1'b1;
      p_addr = star_index;
      p_wdata = '0;
    end else if (pwe) begin
      p_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && opcode == OP_LOAD) begin
      mem_x[star_index] <= load_x;
      mem_y[star_index] <= load_y;
      mem_z[star_index] <= load_z;
    end
    if (zwe) mem_z[idx_r] <= zs;
    if (p_we) mem_p[p_addr] <= p_wdata;
    rd_x <= mem_x[star_index];
    rd_y <= mem_y[star_index];
    rd_z <= mem_z[star_index];
    rd_p <= mem_p[star_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      speed <= '0;
      for (int i = 0; i < 3; i++) ang[i] <= '0;
      for (int i = 0; i < 9; i++) mat[i] <= '0;
      div_start <= 1'b0;
      zwe <= 1'b0;
      pwe <= 1'b0;
    end else begin
      div_start <= (state == S_DIVY) || (state == S_DIVX);
      zwe <= (state == S_READ);
      // clear the last pixel on a step, record it when drawn
      pwe <= (state == S_READ) || (state == S_OUT && col8 < 8'd24);
      if (cfg_we) speed <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 9'd1;
          if (clr_addr == 9'(STAR_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          idx_r <= star_index;
          erase_valid <= 1'b0; erase_col <= '0; erase_row <= '0;
          draw_valid <= 1'b0; draw_col <= '0; draw_row <= '0; shade <= '0;
          if (opcode == OP_LOAD) begin
            state <= S_DONE;
          end else if (opcode == OP_FRAME) begin
            sab_r <= sab; cab_r <= cab;
            state <= S_FRAME;
          end else if (opcode == OP_STEP && in_range) begin
            state <= S_READ;
          end else begin
            state <= S_DONE;
          end
        end
        S_FRAME: begin
          ang[0] <= na0; ang[1] <= na1; ang[2] <= na2;
          mat[0] <= m16(ca, cc) + 16'(2 * m16(sc, sab_r));
          mat[3] <= m16(sa, cb);
          mat[6] <= 16'(2 * m16(cc, sab_r)) - m16(ca, sc);
          mat[1] <= 16'(2 * m16(sc, cab_r)) - m16(sa, cc);
          mat[4] <= m16(ca, cb);
          mat[7] <= m16(sa, sc) + 16'(2 * m16(cc, cab_r));
          mat[2] <= m16(cb, sc);
          mat[5] <= -(sb >>> 1);
          mat[8] <= m16(cb, cc);
          state <= S_DONE;
        end
        S_READ: begin
          if (rd_p[18]) begin
            erase_valid <= 1'b1;
            erase_col <= rd_p[17:8];
            erase_row <= rd_p[7:0];
          end
          mem_wp <= '0;
          lx <= rd_x; ly <= rd_y;
          lz <= rd_z + $signed({6'd0, speed});
          zs <= rd_z + $signed({6'd0, speed});
          mac_cnt <= 2'd0;
          state <= S_MAC;
        end
        S_MAC: begin
          pr0 <= m0 * lx; pr1 <= m1 * ly; pr2 <= m2 * lz;
          state <= S_ACC;
        end
        S_ACC: begin
          if (mac_cnt == 2'd0) begin
            vz <= acc + Z_BIAS;
            if (acc + Z_BIAS <= Z_NEAR) state <= S_DONE;
            else begin mac_cnt <= 2'd1; state <= S_MAC; end
          end else if (mac_cnt == 2'd1) begin
            vy <= acc;
            mac_cnt <= 2'd2;
            state <= S_DIVY;
          end else begin
            vx <= acc;
            state <= S_DIVX;
          end
        end
        S_DIVY: begin
          div_num <= 32'(vy) <<< 7;
          state <= S_WAITY;
        end
        S_WAITY: if (div_done) begin
          py_r <= py_w;
          if (py_w >= ROW_LIM) state <= S_DONE;
          else state <= S_MAC;
        end
        S_DIVX: begin
          div_num <= tx <<< 7;
          state <= S_WAITX;
        end
        S_WAITX: if (div_done) begin
          px_r <= px_w;
          if (px_w >= COL_LIM) state <= S_DONE;
          else state <= S_OUT;
        end
        S_OUT: begin
          if (col8 < 8'd24) begin
            draw_valid <= 1'b1;
            draw_col <= 10'(px_r + 16'sd4);
            draw_row <= 8'(py_r + 16'sd4);
            shade <= depth_shade(col8[4:0]);
            mem_wp <= {1'b1, 10'(px_r + 16'sd4), 8'(py_r + 16'sd4)};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/srpe_div.sv
// signed restoring divider, truncates toward zero, one quotient bit a cycle
module srpe_div import srpe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [15:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic [31:0] num;
  logic [31:0] rem;
  logic [15:0] den;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, num[31]} - {17'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= dividend[31] ? 32'(-dividend) : dividend;
        den  <= divisor[15] ? 16'(-divisor) : divisor;
        neg  <= dividend[31] ^ divisor[15];
        rem  <= '0;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (!trial[32]) rem <= trial[31:0];
        else rem <= {rem[30:0], num[31]};
        num <= {num[30:0], ~trial[32]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 32'(-num) : num;

endmodule
